// ----- hdl/histogram_bilateral_filter_top_macros.svh -----
`ifndef HISTOGRAM_BILATERAL_FILTER_TOP_MACROS_SVH
`define HISTOGRAM_BILATERAL_FILTER_TOP_MACROS_SVH

// Check that prop holds in the same cycle as cond.
`define HBF_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hbf same-cycle check failed");

// Check that prop holds in the cycle after cond.
`define HBF_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hbf next-cycle check failed");

`endif

// ----- hdl/hbf_pkg.sv -----
`default_nettype none

package hbf_pkg;

    localparam int BINS       = 256;
    localparam int PIX_W      = 8;
    localparam int DIFF_W     = 8;
    localparam int WEIGHT_W   = 17;
    localparam int OUT_W      = 16;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 13;
    localparam int RADIUS_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_CWAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        logic accept_pixel;
        logic write_weight;
        logic center_read;
        logic capture_center;
        logic scan_issue;
        logic div_start;
        logic load_out;
    } hbf_cmd_t;

    typedef struct packed {
        logic produce;
        logic scan_last;
        logic pipe_empty;
        logic div_done;
        logic out_busy;
    } hbf_sts_t;

endpackage

`default_nettype wire

// ----- hdl/hbf_channels.sv -----
`default_nettype none

interface hbf_in_if;
    import hbf_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [DIFF_W-1:0]   weight_index;
    logic [WEIGHT_W-1:0] weight_value;
    logic [PIX_W-1:0]    pixel;
    modport source (output valid, func, weight_index, weight_value, pixel, input ready);
    modport sink (input valid, func, weight_index, weight_value, pixel, output ready);
endinterface

interface hbf_out_if;
    import hbf_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] filtered_value;
    logic             zero_weight;
    logic             last_of_frame;
    modport source (output valid, filtered_value, zero_weight, last_of_frame, input ready);
    modport sink (input valid, filtered_value, zero_weight, last_of_frame, output ready);
endinterface

interface hbf_cfg_if;
    import hbf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/hbf_ram.sv -----
`default_nettype none

module hbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hbf_divider.sv -----
`default_nettype none

module hbf_divider #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_W-1:0]        num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic [hbf_pkg::OUT_W-1:0] quotient,
    output logic                    zero
);
    import hbf_pkg::*;

    localparam int DV_W  = NUM_W + 9;
    localparam int CNT_W = $clog2(DV_W + 1);

    logic [DV_W-1:0]  dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [OUT_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             zero_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DV_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // Scale to Q8.8 and add half the divisor for round half up.
            dvd_reg  <= {1'b0, num, 8'd0} + DV_W'(den >> 1);
            rem_reg  <= '0;
            den_reg  <= den;
            quo_reg  <= '0;
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DV_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[OUT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign zero     = zero_reg;

endmodule

`default_nettype wire

// ----- hdl/hbf_ctrl.sv -----
`default_nettype none

module hbf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    input  hbf_pkg::hbf_sts_t sts,
    output hbf_pkg::hbf_cmd_t cmd,
    output logic              in_ready
);
    import hbf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_func == FUNC_PIXEL && sts.produce)
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: state_next = ST_CWAIT;
            ST_CWAIT:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_done && !sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready         = 1'b1;
                cmd.accept_pixel = in_valid && in_func == FUNC_PIXEL;
                cmd.write_weight = in_valid && in_func == FUNC_WEIGHT;
            end
            ST_CENTER: cmd.center_read    = 1'b1;
            ST_CWAIT:  cmd.capture_center = 1'b1;
            ST_SCAN:   cmd.scan_issue     = 1'b1;
            ST_DRAIN:  cmd.div_start      = sts.pipe_empty;
            ST_DIVIDE: cmd.load_out       = sts.div_done && !sts.out_busy;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/hbf_datapath.sv -----
`default_nettype none

module hbf_datapath #(
    parameter int MAX_RADIUS       = 8,
    parameter int MAX_PADDED_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hbf_pkg::hbf_cmd_t               cmd,
    output hbf_pkg::hbf_sts_t               sts,
    input  logic                            cfg_we,
    input  logic [hbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [hbf_pkg::DIFF_W-1:0]      weight_index,
    input  logic [hbf_pkg::WEIGHT_W-1:0]    weight_value,
    input  logic [hbf_pkg::PIX_W-1:0]       pixel,
    input  logic                            out_take,
    output logic                            out_valid,
    output logic [hbf_pkg::OUT_W-1:0]       filtered_value,
    output logic                            zero_weight,
    output logic                            last_of_frame
);
    import hbf_pkg::*;

    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int RLIM   = (MAX_RADIUS < (MAX_PADDED_WIDTH - 1) / 2) ?
                            MAX_RADIUS : (MAX_PADDED_WIDTH - 1) / 2;
    localparam int RING_W = $clog2(RING);
    localparam int DY_W   = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_PADDED_WIDTH);
    localparam int PW_W   = $clog2(MAX_PADDED_WIDTH + 1);
    localparam int ROW_W  = HEIGHT_W;
    localparam int GEO_W  = 14;
    localparam int TWO_W  = RADIUS_W + 1;
    localparam int DEPTH  = RING * MAX_PADDED_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam longint NUM_MAX = longint'(RING) * RING * 255 * 65536;
    localparam longint DEN_MAX = longint'(RING) * RING * 65536;
    localparam int NUM_W  = $clog2(NUM_MAX + 1);
    localparam int DEN_W  = $clog2(DEN_MAX + 1);
    localparam int PROD_W = PIX_W + WEIGHT_W;

    function automatic logic [RING_W-1:0] ring_back(input logic [RING_W-1:0] ring,
                                                    input logic [TWO_W-1:0]  k);
        logic [RING_W:0] t;
        t = {1'b0, ring} + (RING_W+1)'(RING) - (RING_W+1)'(k);
        if (t >= (RING_W+1)'(RING))
        begin
            t = t - (RING_W+1)'(RING);
        end
        return t[RING_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [RING_W-1:0] ring,
                                                     input logic [COL_W-1:0]  col);
        return ADDR_W'(ring) * ADDR_W'(MAX_PADDED_WIDTH) + ADDR_W'(col);
    endfunction

    // Configuration and frame position
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [COL_W-1:0]    col_pos_reg;
    logic [ROW_W-1:0]    row_pos_reg;
    logic [RING_W-1:0]   ring_pos_reg;

    logic [RADIUS_W-1:0] r;
    logic [TWO_W-1:0]    two_r;
    logic [GEO_W-1:0]    w_eff;
    logic [GEO_W-1:0]    h_eff;
    logic [PW_W-1:0]     pw;
    logic [ROW_W-1:0]    ph;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;
    logic [RING_W-1:0]   ring_cur;
    logic [PW_W-1:0]     col_inc;
    logic [ROW_W:0]      row_inc;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_next;
    logic [RING_W-1:0]   ring_next;
    logic                produce;
    logic                last_cur;

    always_comb
    begin
        r = radius_reg;
        if (int'(radius_reg) > RLIM)
        begin
            r = RADIUS_W'(RLIM);
        end
        two_r = {r, 1'b0};

        w_eff = (width_reg == '0) ? GEO_W'(1) : GEO_W'(width_reg);
        if (w_eff + GEO_W'(two_r) > GEO_W'(MAX_PADDED_WIDTH))
        begin
            w_eff = GEO_W'(MAX_PADDED_WIDTH) - GEO_W'(two_r);
        end
        h_eff = (height_reg == '0) ? GEO_W'(1) : GEO_W'(height_reg);
        if (h_eff + GEO_W'(two_r) > GEO_W'(HEIGHT_LIMIT))
        begin
            h_eff = GEO_W'(HEIGHT_LIMIT) - GEO_W'(two_r);
        end
        pw = PW_W'(w_eff + GEO_W'(two_r));
        ph = ROW_W'(h_eff + GEO_W'(two_r));

        col_cur = (PW_W'(col_pos_reg) >= pw) ? '0 : col_pos_reg;
        row_cur = row_pos_reg;
        ring_cur = ring_pos_reg;
        if (row_pos_reg >= ph)
        begin
            row_cur  = '0;
            ring_cur = '0;
        end

        produce  = (GEO_W'(row_cur) >= GEO_W'(two_r)) && (GEO_W'(col_cur) >= GEO_W'(two_r));
        last_cur = (row_cur == ph - 1'b1) && (PW_W'(col_cur) == pw - 1'b1);

        // Advance raster position, wrapping line and frame.
        col_inc   = PW_W'(col_cur) + 1'b1;
        row_inc   = {1'b0, row_cur} + 1'b1;
        col_next  = COL_W'(col_inc);
        row_next  = row_cur;
        ring_next = ring_cur;
        if (col_inc >= pw)
        begin
            col_next = '0;
            if (row_inc >= {1'b0, ph})
            begin
                row_next  = '0;
                ring_next = '0;
            end
            else
            begin
                row_next  = row_inc[ROW_W-1:0];
                ring_next = (ring_cur == RING_W'(RING - 1)) ? '0 : ring_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_W'(64);
            height_reg   <= HEIGHT_W'(64);
            radius_reg   <= RADIUS_W'(2);
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            ring_pos_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_RADIUS:       radius_reg <= cfg_data[RADIUS_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
            // Any known register restarts the frame.
            if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
                cfg_index == CFG_RADIUS)
            begin
                col_pos_reg  <= '0;
                row_pos_reg  <= '0;
                ring_pos_reg <= '0;
            end
        end
        else if (cmd.accept_pixel)
        begin
            col_pos_reg  <= col_next;
            row_pos_reg  <= row_next;
            ring_pos_reg <= ring_next;
        end
    end

    // Item context and window walk
    logic [COL_W-1:0]  col_q_reg;
    logic [RING_W-1:0] ring_q_reg;
    logic              last_q_reg;
    logic [DY_W-1:0]   dy_reg;
    logic [DY_W-1:0]   dx_reg;
    logic [RING_W-1:0] ring_scan_reg;
    logic [COL_W-1:0]  colbase_reg;
    logic [PIX_W-1:0]  center_reg;
    logic              scan_last;

    assign scan_last = (int'(dy_reg) == int'(two_r)) && (int'(dx_reg) == int'(two_r));

    always_ff @(posedge clk)
    begin
        if (cmd.accept_pixel)
        begin
            col_q_reg  <= col_cur;
            ring_q_reg <= ring_cur;
            last_q_reg <= last_cur;
        end
        if (cmd.center_read)
        begin
            dy_reg        <= '0;
            dx_reg        <= '0;
            ring_scan_reg <= ring_back(ring_q_reg, two_r);
            colbase_reg   <= col_q_reg - COL_W'(two_r);
        end
        else if (cmd.scan_issue)
        begin
            if (int'(dx_reg) == int'(two_r))
            begin
                dx_reg        <= '0;
                dy_reg        <= dy_reg + 1'b1;
                ring_scan_reg <= (ring_scan_reg == RING_W'(RING - 1)) ? '0 :
                                 ring_scan_reg + 1'b1;
            end
            else
            begin
                dx_reg <= dx_reg + 1'b1;
            end
        end
    end

    // Line store
    logic [ADDR_W-1:0] store_raddr;
    logic [PIX_W-1:0]  store_rdata;

    assign store_raddr = cmd.center_read ?
                         store_addr(ring_back(ring_q_reg, TWO_W'(r)), col_q_reg - COL_W'(r)) :
                         store_addr(ring_scan_reg, colbase_reg + COL_W'(dx_reg));

    hbf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.accept_pixel),
        .waddr (store_addr(ring_cur, col_cur)),
        .wdata (pixel),
        .re    (cmd.center_read || cmd.scan_issue),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture_center)
        begin
            center_reg <= store_rdata;
        end
    end

    // Weight table with per-entry valid bits (unwritten entries read zero)
    logic [BINS-1:0]     wvalid_reg;
    logic                wvalid_q_reg;
    logic [WEIGHT_W-1:0] weight_rdata;
    logic [WEIGHT_W-1:0] weight_clamped;
    logic [DIFF_W-1:0]   diff;
    logic [WEIGHT_W-1:0] weight_eff;
    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;

    assign weight_clamped = (weight_value > WEIGHT_ONE) ? WEIGHT_ONE : weight_value;
    assign diff = (store_rdata > center_reg) ? store_rdata - center_reg :
                                               center_reg - store_rdata;
    assign weight_eff = wvalid_q_reg ? weight_rdata : '0;

    hbf_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (BINS)
    ) u_weight_table (
        .clk   (clk),
        .we    (cmd.write_weight),
        .waddr (weight_index),
        .wdata (weight_clamped),
        .re    (v1_reg),
        .raddr (diff),
        .rdata (weight_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
        end
        else if (cmd.write_weight)
        begin
            wvalid_reg[weight_index] <= 1'b1;
        end
    end

    // Multiply-accumulate pipe
    logic [PIX_W-1:0]  p2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [WEIGHT_W-1:0] w3_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p2_reg       <= store_rdata;
            wvalid_q_reg <= wvalid_reg[diff];
        end
        if (v2_reg)
        begin
            prod_reg <= p2_reg * weight_eff;
            w3_reg   <= weight_eff;
        end
        if (cmd.center_read)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (v3_reg)
        begin
            num_reg <= num_reg + NUM_W'(prod_reg);
            den_reg <= den_reg + DEN_W'(w3_reg);
        end
    end

    // Divide and result register
    logic             div_done;
    logic [OUT_W-1:0] quotient;
    logic             div_zero;
    logic             out_valid_reg;
    logic [OUT_W-1:0] value_reg;
    logic             zero_reg;
    logic             last_reg;

    hbf_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (num_reg),
        .den      (den_reg),
        .done     (div_done),
        .quotient (quotient),
        .zero     (div_zero)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            value_reg <= div_zero ? '0 : quotient;
            zero_reg  <= div_zero;
            last_reg  <= last_q_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = value_reg;
    assign zero_weight    = zero_reg;
    assign last_of_frame  = last_reg;

    always_comb
    begin
        sts.produce    = produce;
        sts.scan_last  = scan_last;
        sts.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
        sts.div_done   = div_done;
        sts.out_busy   = out_valid_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/histogram_bilateral_filter_top.sv -----
// A weight write or a pixel that completes no window is handled in IDLE.
// A pixel that completes a window has its result valid after it is taken and
// goes through two center states, one line-store read per window pixel, a 3-stage
// MAC pipe that drains, a 42-step bit-serial divider and a wait for a free result.
// Throughput: one item at a time; next item taken once the result is loaded.
// Reset: registers to 64/64/2, positions zero, weight table reads zero until written.
`default_nettype none
`include "histogram_bilateral_filter_top_macros.svh"

module histogram_bilateral_filter_top #(
    parameter int MAX_RADIUS       = 8,
    parameter int MAX_PADDED_WIDTH = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    hbf_in_if.sink   items,
    hbf_out_if.source results,
    hbf_cfg_if.sink  cfg
);
    import hbf_pkg::*;

    hbf_cmd_t cmd;
    hbf_sts_t sts;
    logic     out_valid;

    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid;

    hbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_func  (items.func),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (items.ready)
    );

    hbf_datapath #(
        .MAX_RADIUS       (MAX_RADIUS),
        .MAX_PADDED_WIDTH (MAX_PADDED_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .weight_index   (items.weight_index),
        .weight_value   (items.weight_value),
        .pixel          (items.pixel),
        .out_take       (results.valid && results.ready),
        .out_valid      (out_valid),
        .filtered_value (results.filtered_value),
        .zero_weight    (results.zero_weight),
        .last_of_frame  (results.last_of_frame)
    );

    // The line store has one user per cycle: a pixel write, a center read or a scan read.
    `HBF_ASSERT_IMPLY(a_store_port, 1'b1, $onehot0({cmd.accept_pixel, cmd.center_read, cmd.scan_issue}))
    `HBF_ASSERT_IMPLY(a_div_after_drain, cmd.div_start, sts.pipe_empty)
    `HBF_ASSERT_IMPLY(a_load_free, cmd.load_out, !out_valid)
    `HBF_ASSERT_NEXT(a_window_busy, cmd.accept_pixel && sts.produce, !items.ready)

endmodule

`default_nettype wire
